/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the console engine RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and codes of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // request types
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // control characters
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    localparam logic [7:0]  BLANK_CHAR = 8'h20;
    localparam logic [15:0] RESET_WORD = 16'h0720;
    localparam logic [7:0]  RESET_ATTR = 8'h07;

    localparam int Q_DEPTH = 2;

    // classified operation carried from front to back
    typedef enum logic [2:0] {
        OP_PUT,
        OP_BS,
        OP_TAB,
        OP_LF,
        OP_CR,
        OP_NOP,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  ch;
        logic [10:0] idx;
    } t_q_entry;

    typedef struct packed {
        logic [4:0]  cursor_line;
        logic [6:0]  cursor_column;
        logic [10:0] cursor_position;
        logic        cell_written;
        logic [10:0] write_index;
        logic [15:0] write_word;
        logic        did_scroll;
        logic [15:0] read_word;
    } t_result;

endpackage

/* rtl/tcce_ram.sv */
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcce_fifo.sv */
// ----------------------------------------------------------------------------
// tcce_fifo
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcce_pkg::t_q_entry i_entry,
    input  logic              i_pop,
    output tcce_pkg::t_q_entry o_head,
    output logic              o_full,
    output logic              o_empty
);
    import tcce_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_q_entry         r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_count, n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == QAW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QAW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_count == QCW'(Q_DEPTH));
    assign o_empty = (r_count == '0);

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

/* rtl/tcce_front.sv */
// ----------------------------------------------------------------------------
// tcce_front
// Input side: accepts requests and classifies them into queue operations.
// ----------------------------------------------------------------------------
module tcce_front #(
    parameter int LINES   = 25,
    parameter int COLUMNS = 80
) (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_char_code,
    input  logic [10:0]        i_cell_index,
    input  logic               i_init_busy,
    input  logic               i_full,
    output logic               o_push,
    output tcce_pkg::t_q_entry o_entry
);
    import tcce_pkg::*;

    localparam int CELLS = LINES * COLUMNS;

    logic printable;
    t_op  op;

    // 0x20..0x7F
    assign printable = !i_char_code[7] && (i_char_code[6:5] != 2'b00);

    always_comb begin
        op = OP_NOP;
        unique case (i_req_type)
            REQ_PUT: begin
                priority if (i_char_code == CH_BS) begin
                    op = OP_BS;
                end else if (i_char_code == CH_TAB) begin
                    op = OP_TAB;
                end else if (i_char_code == CH_LF) begin
                    op = OP_LF;
                end else if (i_char_code == CH_CR) begin
                    op = OP_CR;
                end else if (printable) begin
                    op = OP_PUT;
                end else begin
                    op = OP_NOP;
                end
            end
            REQ_CLEAR: op = OP_CLEAR;
            REQ_READ:  op = (32'(i_cell_index) < CELLS) ? OP_READ : OP_NOP;
            default:   op = OP_NOP;
        endcase
    end

    assign o_ready     = !i_full && !i_init_busy;
    assign o_push      = i_valid && o_ready;
    assign o_entry.op  = op;
    assign o_entry.ch  = i_char_code;
    assign o_entry.idx = i_cell_index;

endmodule

/* rtl/tcce_back.sv */
// ----------------------------------------------------------------------------
// tcce_back
// Execution side: cursor, screen store sequencing (fill, scroll, read) and
// the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_back #(
    parameter int LINES     = 25,
    parameter int COLUMNS   = 80,
    parameter int TAB_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_attr,
    input  logic               i_empty,
    input  tcce_pkg::t_q_entry i_head,
    output logic               o_pop,
    output logic               o_init_busy,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcce_pkg::t_result  o_result
);
    import tcce_pkg::*;

    localparam int CELLS       = LINES * COLUMNS;
    localparam int LW          = $clog2(LINES);
    localparam int CW          = $clog2(COLUMNS + 1);
    localparam int AW          = $clog2(CELLS);
    localparam int PW          = $clog2(CELLS + 1);
    localparam int NSTOPS      = COLUMNS / TAB_WIDTH;
    localparam int SCROLL_BASE = CELLS - COLUMNS;

    typedef enum logic [5:0] {
        S_INIT         = 6'b000001,
        S_IDLE         = 6'b000010,
        S_CLEAR        = 6'b000100,
        S_READ         = 6'b001000,
        S_SCROLL_COPY  = 6'b010000,
        S_SCROLL_BLANK = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_line, n_line;
    logic [CW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_cp_v, n_cp_v;
    logic [AW-1:0]   r_cp_addr, n_cp_addr;
    logic            r_pend_char, n_pend_char;
    logic [15:0]     r_pend_word, n_pend_word;
    t_result         r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    logic            out_free;
    logic            at_last_line;
    logic            col_full;
    logic [LW-1:0]   put_row;
    logic [AW-1:0]   put_addr;
    logic [15:0]     put_word;
    logic [15:0]     blank_word;
    logic [AW-1:0]   read_addr;
    logic [31:0]     idx32;
    logic            done_cursor;

    tcce_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // first multiple of TAB_WIDTH above the column, saturated at row width
    function automatic logic [CW-1:0] tab_stop(input logic [CW-1:0] cl);
        logic [CW-1:0] res;
        res = CW'(COLUMNS);
        for (int k = NSTOPS; k >= 1; k--) begin
            if (32'(cl) < k * TAB_WIDTH) begin
                res = CW'(k * TAB_WIDTH);
            end
        end
        return res;
    endfunction

    function automatic t_result make_result(
        input logic [LW-1:0] ln,
        input logic [CW-1:0] cl,
        input logic          wr,
        input logic [AW-1:0] wa,
        input logic [15:0]   ww,
        input logic          sc,
        input logic [15:0]   rw
    );
        logic [PW-1:0] pos;
        logic [31:0]   ln32;
        logic [31:0]   cl32;
        logic [31:0]   pos32;
        logic [31:0]   wa32;
        t_result       res;
        pos   = PW'(ln) * PW'(COLUMNS) + PW'(cl);
        ln32  = 32'(ln);
        cl32  = 32'(cl);
        pos32 = 32'(pos);
        wa32  = 32'(wa);
        res.cursor_line     = ln32[4:0];
        res.cursor_column   = cl32[6:0];
        res.cursor_position = pos32[10:0];
        res.cell_written    = wr;
        res.write_index     = wa32[10:0];
        res.write_word      = ww;
        res.did_scroll      = sc;
        res.read_word       = rw;
        return res;
    endfunction

    assign out_free     = !r_out_valid || i_out_ready;
    assign at_last_line = (r_line == LW'(LINES - 1));
    assign col_full     = (r_col == CW'(COLUMNS));
    assign put_row      = col_full ? r_line + 1'b1 : r_line;
    assign put_addr     = AW'(put_row) * AW'(COLUMNS) + (col_full ? '0 : AW'(r_col));
    assign put_word     = {i_attr, i_head.ch};
    assign blank_word   = {i_attr, BLANK_CHAR};
    assign idx32        = 32'(i_head.idx);
    assign read_addr    = idx32[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_cp_v      = 1'b0;
        n_cp_addr   = r_cp_addr;
        n_pend_char = r_pend_char;
        n_pend_word = r_pend_word;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt;
        ram_wdata   = blank_word;
        ram_raddr   = read_addr;
        o_pop       = 1'b0;
        done_cursor = 1'b0;

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (r_state == S_INIT) ? RESET_WORD : blank_word;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    if (r_state == S_CLEAR) begin
                        n_line      = '0;
                        n_col       = '0;
                        done_cursor = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        OP_PUT: begin
                            if (col_full && at_last_line) begin
                                n_pend_char = 1'b1;
                                n_pend_word = put_word;
                                n_cnt       = '0;
                                n_state     = S_SCROLL_COPY;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = put_addr;
                                ram_wdata   = put_word;
                                n_line      = put_row;
                                n_col       = col_full ? CW'(1) : r_col + 1'b1;
                                n_out       = make_result(n_line, n_col, 1'b1, put_addr,
                                                          put_word, 1'b0, 16'h0);
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_LF: begin
                            if (at_last_line) begin
                                n_pend_char = 1'b0;
                                n_cnt       = '0;
                                n_state     = S_SCROLL_COPY;
                            end else begin
                                n_line      = r_line + 1'b1;
                                n_col       = '0;
                                done_cursor = 1'b1;
                            end
                        end
                        OP_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end else if (r_line != '0) begin
                                n_col  = CW'(COLUMNS - 1);
                                n_line = r_line - 1'b1;
                            end
                            done_cursor = 1'b1;
                        end
                        OP_TAB: begin
                            n_col       = tab_stop(r_col);
                            done_cursor = 1'b1;
                        end
                        OP_CR: begin
                            n_col       = '0;
                            done_cursor = 1'b1;
                        end
                        OP_NOP: begin
                            done_cursor = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out       = make_result(r_line, r_col, 1'b0, '0, 16'h0, 1'b0, ram_rdata);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCROLL_COPY: begin
                // read one row ahead, write the previous read back one row up
                ram_raddr = r_cnt + AW'(COLUMNS);
                n_cp_v    = 1'b1;
                n_cp_addr = r_cnt;
                if (r_cp_v) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cp_addr;
                    ram_wdata = ram_rdata;
                end
                if (r_cnt == AW'(SCROLL_BASE - 1)) begin
                    n_cnt   = AW'(SCROLL_BASE);
                    n_state = S_SCROLL_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCROLL_BLANK: begin
                ram_we = 1'b1;
                if (r_cp_v) begin
                    // drain the last copied cell first
                    ram_waddr = r_cp_addr;
                    ram_wdata = ram_rdata;
                end else begin
                    ram_waddr = r_cnt;
                    ram_wdata = (r_pend_char && r_cnt == AW'(SCROLL_BASE)) ?
                                r_pend_word : blank_word;
                    if (r_cnt == AW'(CELLS - 1)) begin
                        n_line      = LW'(LINES - 1);
                        n_col       = r_pend_char ? CW'(1) : '0;
                        n_out       = make_result(n_line, n_col, r_pend_char,
                                                  r_pend_char ? AW'(SCROLL_BASE) : '0,
                                                  r_pend_char ? r_pend_word : 16'h0,
                                                  1'b1, 16'h0);
                        n_out_valid = 1'b1;
                        n_pend_char = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done_cursor) begin
            n_out       = make_result(n_line, n_col, 1'b0, '0, 16'h0, 1'b0, 16'h0);
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_line      <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_cp_v      <= 1'b0;
            r_pend_char <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
            r_cp_v      <= n_cp_v;
            r_pend_char <= n_pend_char;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr   <= n_cp_addr;
        r_pend_word <= n_pend_word;
        r_out       <= n_out;
    end

    assign o_init_busy = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `ASSERT_ALWAYS(a_cursor_range, i_clk, i_rst_n, (32'(r_col) <= COLUMNS) && (32'(r_line) < LINES), "cursor out of screen")
    `ASSERT_IMPLIES(a_pop_slot_free, i_clk, i_rst_n, o_pop, !r_out_valid || i_out_ready, "pop while result slot busy")
    `ASSERT_IMPLIES(a_copy_dest, i_clk, i_rst_n, r_cp_v, 32'(r_cp_addr) < SCROLL_BASE, "scroll copy into bottom row")
    `ASSERT_IMPLIES(a_init_silent, i_clk, i_rst_n, r_state == S_INIT, !r_out_valid, "result during reset fill")

endmodule

/* rtl/text_console_char_engine_top.sv */
// ----------------------------------------------------------------------------
// text_console_char_engine_top
// Text console: screen store of LINES x COLUMNS cells plus cursor.
// ----------------------------------------------------------------------------
// Requests enter on the i_valid/o_ready channel (put character, clear, read
// cell); every request yields one result on o_valid/i_ready carrying the
// cursor and any stored or read cell word. i_cfg_wr_en writes the attribute
// byte; write it only while no request is in flight.
// A two-entry queue separates request intake from execution, and a result
// register separates execution from the receiver, so intake continues while
// a result waits. When the receiver stalls, the queue fills and o_ready drops.
// Execution takes one cursor move or character per cycle while the receiver
// takes each result and no scroll is running; after a cell read it returns
// to idle before taking the next request. All are bounded by the single
// write and read port of the screen RAM. Clear screen writes one cell per
// cycle; a scroll copies the rows up and then blanks the bottom row. After
// reset the screen RAM is filled with blank cells (LINES*COLUMNS, 2000 at
// defaults) with o_ready low; attribute writes are taken.
// ----------------------------------------------------------------------------
module text_console_char_engine_top #(
    parameter int LINES     = 25,
    parameter int COLUMNS   = 80,
    parameter int TAB_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_cursor_line,
    output logic [6:0]  o_cursor_column,
    output logic [10:0] o_cursor_position,
    output logic        o_cell_written,
    output logic [10:0] o_write_index,
    output logic [15:0] o_write_word,
    output logic        o_did_scroll,
    output logic [15:0] o_read_word
);
    import tcce_pkg::*;

    logic [7:0] r_text_attr;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic       init_busy;
    t_q_entry   entry;
    t_q_entry   head;
    t_result    result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= RESET_ATTR;
        end else if (i_cfg_wr_en) begin
            r_text_attr <= i_cfg_wr_data;
        end
    end

    tcce_front #(
        .LINES  (LINES),
        .COLUMNS(COLUMNS)
    ) u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_char_code (i_char_code),
        .i_cell_index(i_cell_index),
        .i_init_busy (init_busy),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (entry)
    );

    tcce_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(entry),
        .i_pop  (pop),
        .o_head (head),
        .o_full (full),
        .o_empty(empty)
    );

    tcce_back #(
        .LINES    (LINES),
        .COLUMNS  (COLUMNS),
        .TAB_WIDTH(TAB_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_attr     (r_text_attr),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_init_busy(init_busy),
        .o_out_valid(o_valid),
        .i_out_ready(i_ready),
        .o_result   (result)
    );

    assign o_cursor_line     = result.cursor_line;
    assign o_cursor_column   = result.cursor_column;
    assign o_cursor_position = result.cursor_position;
    assign o_cell_written    = result.cell_written;
    assign o_write_index     = result.write_index;
    assign o_write_word      = result.write_word;
    assign o_did_scroll      = result.did_scroll;
    assign o_read_word       = result.read_word;

endmodule
